// ===== hw/rtl/nts_pkg.sv =====
// ----------------------------------------------------------------------------
// nts_pkg
// shared types and constants of the nearest timestamp search unit
// ----------------------------------------------------------------------------
package nts_pkg;

	// table depth default
	localparam int DEPTH_DEF = 2048;

	// fixed field widths
	localparam int OP_W    = 2;
	localparam int STAMP_W = 32;
	localparam int READ_W  = 32;
	localparam int POS_W   = 11;

	// a difference at or above this never counts as a match
	localparam logic [STAMP_W-1:0] FAR_LIMIT = 32'd999999999;

	// item opcodes, code 3 is ignored
	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_QUERY  = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	// result of the shared probe compare unit
	typedef struct packed {
		logic               closer;
		logic               go_right;
		logic [STAMP_W-1:0] diff;
	} probe_t;

	// one finished query result
	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   position;
		logic [STAMP_W-1:0] best_stamp;
		logic [READ_W-1:0]  best_reading;
	} res_t;

endpackage

// ===== hw/rtl/nts_in_if.sv =====
// ----------------------------------------------------------------------------
// nts_in_if
// request channel: append, query or clear items
// ----------------------------------------------------------------------------
interface nts_in_if;

	logic                       valid;
	logic                       ready;
	logic [nts_pkg::OP_W-1:0]    op;
	logic [nts_pkg::STAMP_W-1:0] stamp;
	logic [nts_pkg::READ_W-1:0]  reading;

	modport source (output valid, output op, output stamp, output reading, input ready);
	modport sink   (input valid, input op, input stamp, input reading, output ready);

endinterface

// ===== hw/rtl/nts_out_if.sv =====
// ----------------------------------------------------------------------------
// nts_out_if
// response channel: one item per query
// ----------------------------------------------------------------------------
interface nts_out_if;

	logic                       valid;
	logic                       ready;
	logic                       found;
	logic [nts_pkg::POS_W-1:0]   position;
	logic [nts_pkg::STAMP_W-1:0] best_stamp;
	logic [nts_pkg::READ_W-1:0]  best_reading;

	modport source (output valid, output found, output position, output best_stamp,
		output best_reading, input ready);
	modport sink   (input valid, input found, input position, input best_stamp,
		input best_reading, output ready);

endinterface

// ===== hw/rtl/nts_store.sv =====
// ----------------------------------------------------------------------------
// nts_store
// record memories, one write port and one registered read port
// ----------------------------------------------------------------------------
module nts_store #(
	parameter int DEPTH = nts_pkg::DEPTH_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [nts_pkg::STAMP_W-1:0] wr_stamp,
	input  logic [nts_pkg::READ_W-1:0]  wr_reading,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [nts_pkg::STAMP_W-1:0] rd_stamp,
	output logic [nts_pkg::READ_W-1:0]  rd_reading
);

	logic [nts_pkg::STAMP_W-1:0] stamp_mem [DEPTH];
	logic [nts_pkg::READ_W-1:0]  reading_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stamp_mem[wr_addr]   <= wr_stamp;
			reading_mem[wr_addr] <= wr_reading;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_stamp   <= stamp_mem[rd_addr];
			rd_reading <= reading_mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/nts_probe.sv =====
// ----------------------------------------------------------------------------
// nts_probe
// shared compare unit: distance to the key and search direction
// ----------------------------------------------------------------------------
module nts_probe (
	input  logic [nts_pkg::STAMP_W-1:0] probe_stamp,
	input  logic [nts_pkg::STAMP_W-1:0] key,
	input  logic [nts_pkg::STAMP_W-1:0] best_diff,
	output nts_pkg::probe_t             result
);

	logic above;

	assign above = probe_stamp > key;

	always_comb begin
		result.go_right = above;
		result.diff     = above ? (probe_stamp - key) : (key - probe_stamp);
		result.closer   = result.diff < best_diff;
	end

endmodule

// ===== hw/rtl/nts_seq.sv =====
// ----------------------------------------------------------------------------
// nts_seq
// sequencer: table fill, binary search probes and best record tracking
// ----------------------------------------------------------------------------
module nts_seq #(
	parameter int DEPTH = nts_pkg::DEPTH_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	nts_in_if.sink                      req,
	// record memory
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [nts_pkg::STAMP_W-1:0] wr_stamp,
	output logic [nts_pkg::READ_W-1:0]  wr_reading,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	input  logic [nts_pkg::STAMP_W-1:0] rd_stamp,
	input  logic [nts_pkg::READ_W-1:0]  rd_reading,
	// shared compare unit
	output logic [nts_pkg::STAMP_W-1:0] probe_key,
	output logic [nts_pkg::STAMP_W-1:0] probe_best,
	input  nts_pkg::probe_t             probe,
	// result hand-off
	output logic                        res_valid,
	output nts_pkg::res_t               res,
	input  logic                        res_take,
	output logic [CW-1:0]               fill_count
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_PROBE = 3'b010,
		S_DONE  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [CW-1:0]               count_q;
	logic [CW-1:0]               lo_q;
	logic [CW-1:0]               hi_q;
	logic [CW-1:0]               lo_d;
	logic [CW-1:0]               hi_d;
	logic [CW-1:0]               mid_d;
	logic [AW-1:0]               mid_q;
	logic [nts_pkg::STAMP_W-1:0] key_q;
	logic [nts_pkg::STAMP_W-1:0] best_diff_q;
	logic                        have_q;
	logic [AW-1:0]               best_idx_q;
	logic [nts_pkg::STAMP_W-1:0] best_stamp_q;
	logic [nts_pkg::READ_W-1:0]  best_reading_q;
	logic                        accept;
	logic                        start;
	logic                        span_ok;
	logic                        room;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign start     = accept && (req.op == nts_pkg::OP_QUERY);
	assign room      = count_q < CW'(DEPTH);

	// appends go straight into the memories at the fill count while there is room
	assign wr_en      = accept && (req.op == nts_pkg::OP_APPEND) && room;
	assign wr_addr    = count_q[AW-1:0];
	assign wr_stamp   = req.stamp;
	assign wr_reading = req.reading;

	// next search interval, hi is exclusive
	always_comb begin
		lo_d = lo_q;
		hi_d = hi_q;
		if (state_q == S_IDLE) begin
			lo_d = '0;
			hi_d = count_q;
		end else if (state_q == S_PROBE) begin
			if (probe.go_right) begin
				lo_d = CW'(mid_q) + 1'b1;
			end else begin
				hi_d = CW'(mid_q);
			end
		end
	end

	assign span_ok = lo_d < hi_d;
	assign mid_d   = lo_d + ((hi_d - lo_d - 1'b1) >> 1);
	assign rd_en   = (start || (state_q == S_PROBE)) && span_ok;
	assign rd_addr = mid_d[AW-1:0];

	assign probe_key  = key_q;
	assign probe_best = best_diff_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = span_ok ? S_PROBE : S_DONE;
				end
			end
			S_PROBE: begin
				if (!span_ok) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			have_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end else if (accept && (req.op == nts_pkg::OP_CLEAR)) begin
				count_q <= '0;
			end
			if (start || (state_q == S_PROBE)) begin
				lo_q <= lo_d;
				hi_q <= hi_d;
			end
			if (start) begin
				have_q <= 1'b0;
			end else if ((state_q == S_PROBE) && probe.closer) begin
				have_q <= 1'b1;
			end
		end
	end

	// search payload
	always_ff @(posedge clk) begin
		if (rd_en) begin
			mid_q <= rd_addr;
		end
		if (start) begin
			key_q          <= req.stamp;
			best_diff_q    <= nts_pkg::FAR_LIMIT;
			best_idx_q     <= '0;
			best_stamp_q   <= '0;
			best_reading_q <= '0;
		end else if ((state_q == S_PROBE) && probe.closer) begin
			best_diff_q    <= probe.diff;
			best_idx_q     <= mid_q;
			best_stamp_q   <= rd_stamp;
			best_reading_q <= rd_reading;
		end
	end

	assign res_valid        = (state_q == S_DONE);
	assign res.found        = have_q;
	assign res.position     = nts_pkg::POS_W'(best_idx_q);
	assign res.best_stamp   = best_stamp_q;
	assign res.best_reading = best_reading_q;
	assign fill_count       = count_q;

endmodule

// ===== hw/rtl/nearest_timestamp_search_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_timestamp_search_unit
// append and clear items complete as they are accepted; a query runs P probes,
// where P is at most floor(log2(fill count)) + 1 (at most 12 at full depth,
// none on an empty table), one memory read and one compare in the shared probe
// unit per cycle; a new item is accepted once the result has moved into the
// output register. reset clears the fill count, the sequencer state and the
// output valid flag; the record memories are not cleared.
// ----------------------------------------------------------------------------
module nearest_timestamp_search_unit #(
	parameter int DEPTH = nts_pkg::DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	nts_in_if.sink   req,
	nts_out_if.source rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// memory ports
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [nts_pkg::STAMP_W-1:0] wr_stamp;
	logic [nts_pkg::READ_W-1:0]  wr_reading;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [nts_pkg::STAMP_W-1:0] rd_stamp;
	logic [nts_pkg::READ_W-1:0]  rd_reading;

	// shared compare unit
	logic [nts_pkg::STAMP_W-1:0] probe_key;
	logic [nts_pkg::STAMP_W-1:0] probe_best;
	nts_pkg::probe_t             probe;

	// result hand-off and output register
	logic          res_valid;
	nts_pkg::res_t res;
	logic          res_take;
	logic [CW-1:0] fill_count;
	logic          rsp_valid_q;
	nts_pkg::res_t rsp_q;

	// record tables, read data registered
	nts_store #(.DEPTH(DEPTH)) u_store (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_stamp   (wr_stamp),
		.wr_reading (wr_reading),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_stamp   (rd_stamp),
		.rd_reading (rd_reading)
	);

	// distance and direction of the record just read
	nts_probe u_probe (
		.probe_stamp (rd_stamp),
		.key         (probe_key),
		.best_diff   (probe_best),
		.result      (probe)
	);

	// sequencer: takes items, walks the binary search one probe per cycle
	nts_seq #(.DEPTH(DEPTH)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_stamp   (wr_stamp),
		.wr_reading (wr_reading),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_stamp   (rd_stamp),
		.rd_reading (rd_reading),
		.probe_key  (probe_key),
		.probe_best (probe_best),
		.probe      (probe),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take),
		.fill_count (fill_count)
	);

	// output register: the result moves in when the slot is empty or being drained
	assign res_take = res_valid && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.found        = rsp_q.found;
	assign rsp.position     = rsp_q.position;
	assign rsp.best_stamp   = rsp_q.best_stamp;
	assign rsp.best_reading = rsp_q.best_reading;

	// probes only touch written records
	a_probe_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (CW'(rd_addr) < fill_count))
		else $error("probe address beyond fill count");

	// fill count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count <= CW'(DEPTH))
		else $error("fill count beyond depth");

	// appends and probes never share the memory port
	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !rd_en)
		else $error("write and read in the same cycle");

	// a query holds off further items while it searches
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.op == nts_pkg::OP_QUERY)) |=> !req.ready)
		else $error("item accepted during a query");

endmodule
